// ----- sv/zhang_suen_thinning_pass_assert.svh -----
// ----------------------------------------------------------------------------
// Zhang-Suen thinning pass assertion macros
// Shared concurrent assertion forms used by the thinning pass modules.
// ----------------------------------------------------------------------------
`ifndef ZHANG_SUEN_THINNING_PASS_ASSERT_SVH
`define ZHANG_SUEN_THINNING_PASS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ZST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ZST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/zst_pkg.sv -----
// ----------------------------------------------------------------------------
// Zhang-Suen thinning pass package
// Shared constants, register codes and control structs of the thinning pass.
// ----------------------------------------------------------------------------
package zst_pkg;

  // Default sizes of the line buffers and the pixel path.
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int PIXEL_BITS_DEF = 8;

  // Frame height limit and the row counter that covers it plus the drain rows.
  localparam int HEIGHT_CAP = 512;
  localparam int ROW_W      = $clog2(HEIGHT_CAP + 3);

  // Register values after reset.
  localparam int WIDTH_RST  = 400;
  localparam int HEIGHT_RST = 400;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(2);

  // Input item kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Subiteration codes.
  localparam logic PHASE_SE = 1'b0;
  localparam logic PHASE_NW = 1'b1;

  // Deletion test limits.
  localparam int B_LOW  = 2;
  localparam int B_HIGH = 6;
  localparam int RING   = 8;

  // Settings seen by the datapath.
  typedef struct packed {
    logic             phase;
    logic [ROW_W-1:0] height;
  } zst_cfg_t;

  // Position flags of the window centre that a column completes.
  typedef struct packed {
    logic first_col;  // column 0: flush the previous row's last centre
    logic has_res;    // this column completes a centre inside the frame
    logic top;        // north neighbors lie inside the frame
    logic bot;        // south neighbors lie inside the frame
    logic lft;        // west neighbors lie inside the frame
    logic rgt;        // east neighbors lie inside the frame
    logic last;       // centre is the frame's final pixel
  } zst_pos_t;

endpackage

// ----- sv/zst_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready write channel carrying a register index and its data.
// ----------------------------------------------------------------------------
interface zst_cfg_if import zst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/zst_in_if.sv -----
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one raster pixel or a drain tick.
// ----------------------------------------------------------------------------
interface zst_in_if import zst_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

// ----- sv/zst_out_if.sv -----
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel carrying one thinned pixel and the end-of-frame flag.
// ----------------------------------------------------------------------------
interface zst_out_if import zst_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ----- sv/zst_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Thinning pass configuration registers
// Holds phase, width and height, with width and height clamped on write.
// ----------------------------------------------------------------------------
module zst_cfg_regs import zst_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  zst_cfg_if.sink                          cfg,
  output zst_cfg_t                         cfg_q,
  output logic [$clog2(MAX_WIDTH+1)-1:0]   img_w
);

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  logic             phase_r;
  logic [W_W-1:0]   width_r;
  logic [ROW_W-1:0] height_r;
  logic [W_W-1:0]   width_nxt;
  logic [ROW_W-1:0] height_nxt;
  logic             wr;

  // Writes are taken in any cycle.
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  // A zero size acts as one, and oversize values saturate.
  always_comb begin
    if (cfg.data == '0) begin
      width_nxt = W_W'(1);
    end else if (32'(cfg.data) > MAX_WIDTH) begin
      width_nxt = W_W'(MAX_WIDTH);
    end else begin
      width_nxt = W_W'(cfg.data);
    end
    if (cfg.data == '0) begin
      height_nxt = ROW_W'(1);
    end else if (32'(cfg.data) > HEIGHT_CAP) begin
      height_nxt = ROW_W'(HEIGHT_CAP);
    end else begin
      height_nxt = ROW_W'(cfg.data);
    end
  end

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PHASE_SE;
      width_r  <= W_W'(W_RST);
      height_r <= ROW_W'(HEIGHT_RST);
    end else if (wr) begin
      unique case (cfg.index)
        CFG_PHASE:  phase_r  <= cfg.data[0];
        CFG_WIDTH:  width_r  <= width_nxt;
        CFG_HEIGHT: height_r <= height_nxt;
        default: ;
      endcase
    end
  end

  assign cfg_q.phase  = phase_r;
  assign cfg_q.height = height_r;
  assign img_w        = width_r;

endmodule

// ----- sv/zst_line_buf.sv -----
// ----------------------------------------------------------------------------
// Thinning pass line buffers
// Tracks the raster position, keeps two rows of pixels and presents one
// registered window column per transaction with its position flags.
// ----------------------------------------------------------------------------
`include "zhang_suen_thinning_pass_assert.svh"

module zst_line_buf import zst_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  zst_in_if.sink                         in_s,
  input  zst_cfg_t                       cfg_q,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] img_w,
  output logic                           s1_valid,
  output zst_pos_t                       s1_pos,
  output logic [PIXEL_BITS-1:0]          s1_top,
  output logic [PIXEL_BITS-1:0]          s1_mid,
  output logic [PIXEL_BITS-1:0]          s1_bot,
  input  logic                           s1_adv
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0]      col_r;
  logic [COL_W-1:0]      col_nxt;
  logic [ROW_W-1:0]      row_r;
  logic [ROW_W-1:0]      row_nxt;
  logic [COL_W-1:0]      c;
  logic [ROW_W-1:0]      r;
  logic [W_W-1:0]        c_ext;
  logic [W_W-1:0]        c_inc;
  logic [ROW_W-1:0]      h;
  logic [ROW_W-1:0]      h_inc;
  logic [PIXEL_BITS-1:0] pix;
  zst_pos_t              pos;
  logic                  in_fire;
  logic                  fwd;

  logic [PIXEL_BITS-1:0] above_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] centre_mem [MAX_WIDTH];

  logic                  s1_valid_r;
  logic [COL_W-1:0]      s1_addr_r;
  zst_pos_t              s1_pos_r;
  logic [PIXEL_BITS-1:0] s1_top_r;
  logic [PIXEL_BITS-1:0] s1_mid_r;
  logic [PIXEL_BITS-1:0] s1_bot_r;

  // The column stage takes a new transaction when empty or moving on.
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign in_fire    = in_s.valid && in_s.ready;

  // A drain tick enters as a background pixel.
  assign pix = (in_s.op == OP_DRAIN) ? '0 : in_s.pixel_in;

  // Raster position of this transaction and the position after it.
  always_comb begin
    h     = cfg_q.height;
    h_inc = h + ROW_W'(1);
    if (W_W'(col_r) >= img_w) begin
      c = '0;
      r = row_r + ROW_W'(1);
    end else begin
      c = col_r;
      r = row_r;
    end
    c_ext = W_W'(c);
    c_inc = c_ext + W_W'(1);
    if (c_inc >= img_w) begin
      col_nxt = '0;
      row_nxt = r + ROW_W'(1);
    end else begin
      col_nxt = COL_W'(c_inc);
      row_nxt = r;
    end
    // Past the last drain position the counters wrap to a new frame.
    if (row_nxt > h_inc || (row_nxt == h_inc && col_nxt != '0)) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  // Which centre this column completes and which neighbors lie in the frame.
  always_comb begin
    pos.first_col = (c == '0);
    if (pos.first_col) begin
      // The centre is the last column of the row two rows up.
      pos.has_res = (r >= ROW_W'(2)) && (r <= h_inc);
      pos.top     = (r >= ROW_W'(3));
      pos.bot     = (r <= h);
      pos.lft     = (img_w >= W_W'(2));
      pos.rgt     = 1'b0;
      pos.last    = (r == h_inc);
    end else begin
      // The centre is one column left on the row above; it never ends a row.
      pos.has_res = (r >= ROW_W'(1)) && (r <= h);
      pos.top     = (r >= ROW_W'(2));
      pos.bot     = (r < h);
      pos.lft     = (c >= COL_W'(2));
      pos.rgt     = (c_ext < img_w);
      pos.last    = 1'b0;
    end
  end

  // The column stage writes back the same address that is read now.
  assign fwd = s1_adv && (s1_addr_r == c);

  // Position counters and stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Line buffer read into the column stage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= c;
      s1_pos_r  <= pos;
      s1_bot_r  <= pix;
      if (fwd) begin
        s1_top_r <= s1_mid_r;
        s1_mid_r <= s1_bot_r;
      end else begin
        s1_top_r <= above_mem[c];
        s1_mid_r <= centre_mem[c];
      end
    end
  end

  // Line buffer write: each row moves up by one.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      above_mem[s1_addr_r]  <= s1_mid_r;
      centre_mem[s1_addr_r] <= s1_bot_r;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_pos   = s1_pos_r;
  assign s1_top   = s1_top_r;
  assign s1_mid   = s1_mid_r;
  assign s1_bot   = s1_bot_r;

  `ZST_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_fire, s1_valid_r, "accepted transaction did not reach the column stage")
  `ZST_ASSERT_NEXT(a_stalled_column_holds, clk, rst_n, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_addr_r) && $stable(s1_bot_r), "stalled column changed")
  `ZST_ASSERT_IMPL(a_accept_needs_room, clk, rst_n, in_fire && s1_valid_r, s1_adv, "column stage overwritten")

endmodule

// ----- sv/zst_judge.sv -----
// ----------------------------------------------------------------------------
// Thinning pass window and deletion test
// Shifts columns into the 3x3 window, applies the Zhang-Suen subiteration
// test to the centre and registers the result.
// ----------------------------------------------------------------------------
`include "zhang_suen_thinning_pass_assert.svh"

module zst_judge import zst_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  phase,
  input  logic                  s1_valid,
  input  zst_pos_t              s1_pos,
  input  logic [PIXEL_BITS-1:0] s1_top,
  input  logic [PIXEL_BITS-1:0] s1_mid,
  input  logic [PIXEL_BITS-1:0] s1_bot,
  output logic                  s1_adv,
  zst_out_if.source             out_s
);

  // Window columns, entry 0 north, 1 middle, 2 south.
  logic [PIXEL_BITS-1:0] win_w_r [3];
  logic [PIXEL_BITS-1:0] win_c_r [3];

  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] pixel_out_r;
  logic                  frame_last_r;

  logic [RING-1:0]       p;
  logic [3:0]            b;
  logic [3:0]            a;
  logic                  shape_ok;
  logic                  del;
  logic [PIXEL_BITS-1:0] ctr;
  logic [PIXEL_BITS-1:0] res;

  // A column without a result moves on even while the output is full.
  assign s1_adv = s1_valid && (!s1_pos.has_res || !out_valid_r || out_s.ready);

  // Ring N, NE, E, SE, S, SW, W, NW with the frame edges masked off.
  always_comb begin
    ctr  = win_c_r[1];
    p[0] = s1_pos.top && (win_c_r[0] != '0);
    p[1] = s1_pos.top && s1_pos.rgt && (s1_top != '0);
    p[2] = s1_pos.rgt && (s1_mid != '0);
    p[3] = s1_pos.bot && s1_pos.rgt && (s1_bot != '0);
    p[4] = s1_pos.bot && (win_c_r[2] != '0);
    p[5] = s1_pos.bot && s1_pos.lft && (win_w_r[2] != '0);
    p[6] = s1_pos.lft && (win_w_r[1] != '0);
    p[7] = s1_pos.top && s1_pos.lft && (win_w_r[0] != '0);
  end

  // Foreground count and background-to-foreground transitions.
  always_comb begin
    b = '0;
    a = '0;
    for (int k = 0; k < RING; k++) begin
      b = b + 4'(p[k]);
      a = a + 4'(p[k] && !p[(k + RING - 1) % RING]);
    end
  end

  // Deletion test of the current subiteration.
  always_comb begin
    if (phase == PHASE_SE) begin
      shape_ok = !(p[2] && p[4] && (p[0] || p[6]));
    end else begin
      shape_ok = !(p[0] && p[6] && (p[2] || p[4]));
    end
    del = (ctr != '0) && (b >= 4'(B_LOW)) && (b <= 4'(B_HIGH)) && (a == 4'd1) && shape_ok;
    res = del ? '0 : ctr;
  end

  // Window shift and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_w_r[i] <= '0;
        win_c_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        // A new row starts with background west of its first centre.
        for (int i = 0; i < 3; i++) begin
          win_w_r[i] <= s1_pos.first_col ? '0 : win_c_r[i];
        end
        win_c_r[0] <= s1_top;
        win_c_r[1] <= s1_mid;
        win_c_r[2] <= s1_bot;
      end
      if (s1_adv && s1_pos.has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos.has_res) begin
      pixel_out_r  <= res;
      frame_last_r <= s1_pos.last;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.pixel_out  = pixel_out_r;
  assign out_s.frame_last = frame_last_r;

  `ZST_ASSERT_NEXT(a_result_lands, clk, rst_n, s1_adv && s1_pos.has_res, out_valid_r, "judged centre did not reach the output register")
  `ZST_ASSERT_NEXT(a_row_start_clears_west, clk, rst_n, s1_adv && s1_pos.first_col, win_w_r[0] == '0 && win_w_r[1] == '0 && win_w_r[2] == '0, "west column not cleared at row start")
  `ZST_ASSERT_IMPL(a_no_result_overwrite, clk, rst_n, out_valid_r && !out_s.ready, !(s1_adv && s1_pos.has_res), "waiting result overwritten")

endmodule

// ----- sv/zhang_suen_thinning_pass.sv -----
// ----------------------------------------------------------------------------
// Zhang-Suen thinning pass
// One thinning subiteration over a raster-order image with two line buffers
// and a 3x3 window.
//
//   Channel    Direction  Payload                  Handshake
//   cfg_chan   in         index, data              valid/ready, always ready
//   in_chan    in         op, pixel_in             valid/ready
//   out_chan   out        pixel_out, frame_last    valid/ready, registered
//
// One transaction per cycle enters unless a waiting result stalls the input:
// a column read from the line buffers is registered, and the window test runs
// between that register and the output register. A result leaves one row plus
// one pixel behind the transaction that completes its window, in raster order.
// Reset clears the counters, window and valids; line buffers are not cleared.
// A waiting result stalls the input only when the next column also has one.
// ----------------------------------------------------------------------------
module zhang_suen_thinning_pass import zst_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  zst_cfg_if.sink   cfg_chan,
  zst_in_if.sink    in_chan,
  zst_out_if.source out_chan
);

  zst_cfg_t                       cfg_q;
  logic [$clog2(MAX_WIDTH+1)-1:0] img_w;
  logic                           s1_valid;
  zst_pos_t                       s1_pos;
  logic [PIXEL_BITS-1:0]          s1_top;
  logic [PIXEL_BITS-1:0]          s1_mid;
  logic [PIXEL_BITS-1:0]          s1_bot;
  logic                           s1_adv;

  // Configuration registers.
  zst_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_chan),
    .cfg_q (cfg_q),
    .img_w (img_w)
  );

  // Position tracking and line buffers.
  zst_line_buf #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_chan),
    .cfg_q    (cfg_q),
    .img_w    (img_w),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .s1_top   (s1_top),
    .s1_mid   (s1_mid),
    .s1_bot   (s1_bot),
    .s1_adv   (s1_adv)
  );

  // Window and deletion test.
  zst_judge #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .phase    (cfg_q.phase),
    .s1_valid (s1_valid),
    .s1_pos   (s1_pos),
    .s1_top   (s1_top),
    .s1_mid   (s1_mid),
    .s1_bot   (s1_bot),
    .s1_adv   (s1_adv),
    .out_s    (out_chan)
  );

endmodule
